[hw/rtl/trpte_pkg.sv]
// Shared constants, entry record types and a packing helper for the TLB refill engine.
`default_nettype none

package trpte_pkg;

    localparam int PAGE_ENTRIES = 256;
    localparam int SPARE_START  = 128;
    localparam int TLB_ENTRIES  = 32;

    localparam int IDX_W = $clog2(PAGE_ENTRIES);
    localparam int SP_W  = $clog2(PAGE_ENTRIES + 1);

    localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(PAGE_ENTRIES - 1);
    localparam logic [SP_W:0]    PAGE_END     = (SP_W + 1)'(PAGE_ENTRIES);
    localparam logic [SP_W-1:0]  SPARE_RESET  = SP_W'(SPARE_START);
    localparam logic [6:0]       TLB_END      = 7'(TLB_ENTRIES);

    localparam logic [19:0] FRAME_BASE    = 20'h00080;
    localparam logic [8:0]  OWNER_UNOWNED = 9'h1FF;
    localparam logic [2:0]  LO_COHERENCY  = 3'd2;
    localparam logic        LO_DIRTY      = 1'b1;

    localparam logic ACT_INVALID      = 1'b0;
    localparam logic ACT_REFILL       = 1'b1;
    localparam logic STATUS_LOADED    = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    typedef struct packed {
        logic [19:0] page_number;
        logic [19:0] frame;
        logic        valid;
        logic        claimed;
        logic [8:0]  owner;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           rec;
    } t_wr_req;

    function automatic logic [25:0] pack_lo(input logic [19:0] frame, input logic valid);
        pack_lo = {frame, LO_COHERENCY, LO_DIRTY, valid, 1'b0};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/trpte_table.sv]
// Page table store: one write and one registered read port, per-entry written flags.
`default_nettype none

module trpte_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire trpte_pkg::t_wr_req            i_wr,
    input  wire logic                          i_rd_en,
    input  wire logic [trpte_pkg::IDX_W-1:0]   i_rd_addr,
    output trpte_pkg::t_entry                  o_rd_rec
);

    trpte_pkg::t_entry                 mem [trpte_pkg::PAGE_ENTRIES];
    logic [trpte_pkg::PAGE_ENTRIES-1:0] r_written;
    trpte_pkg::t_entry                 r_rd_data;
    logic                              r_rd_written;
    logic [trpte_pkg::IDX_W-1:0]       r_rd_addr;
    trpte_pkg::t_entry                 reset_rec;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.rec;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_written[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    always_comb begin
        reset_rec.page_number = 20'(r_rd_addr);
        reset_rec.frame       = '0;
        reset_rec.valid       = 1'b0;
        reset_rec.claimed     = 1'b0;
        reset_rec.owner       = trpte_pkg::OWNER_UNOWNED;
        o_rd_rec = r_rd_written ? r_rd_data : reset_rec;
    end

endmodule

`default_nettype wire

[hw/rtl/tlb_refill_page_table_engine.sv]
// A fault scans the table entries in order, then reads, updates and writes back the entry pair.
// A hit at entry k ends the scan at that entry; an invalid fault with no hit gives no result.
// The single read port of the page table store sets the rate: one entry checked per cycle.
// A finished result waits in an output register; the next item is taken meanwhile.
// Reset is synchronous; table entries read as their reset contents until first written,
// so no clearing pass is needed.
`default_nettype none

module tlb_refill_page_table_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [31:0] i_bad_address,
    input  wire logic [5:0]  i_tlb_index,
    input  wire logic [7:0]  i_asid_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_entry_hi,
    output logic [25:0]      o_entry_lo0,
    output logic [25:0]      o_entry_lo1,
    output logic [5:0]       o_tlb_slot,
    output logic             o_status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_CAP1 = 3'd4;
    localparam logic [2:0] S_WR0  = 3'd5;
    localparam logic [2:0] S_WR1  = 3'd6;
    localparam logic [2:0] S_PUSH = 3'd7;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;

    logic                          r_action;
    logic [18:0]                   r_target;
    logic [5:0]                    r_tlb_index;
    logic [7:0]                    r_asid;

    logic [trpte_pkg::IDX_W-1:0]   r_scan_idx;
    logic                          r_issue_done;
    logic                          r_chk_vld;
    logic [trpte_pkg::IDX_W-1:0]   r_chk_idx;
    logic [trpte_pkg::IDX_W-1:0]   r_idx;
    logic                          r_spare;
    logic                          r_exhaust;
    trpte_pkg::t_entry             r_rec0;
    trpte_pkg::t_entry             r_rec1;
    logic [5:0]                    r_slot;

    logic [19:0]                   r_next_frame;
    logic [trpte_pkg::SP_W-1:0]    r_next_spare;
    logic [5:0]                    r_refill_slot;

    logic                          r_out_valid;
    logic [31:0]                   r_entry_hi;
    logic [25:0]                   r_entry_lo0;
    logic [25:0]                   r_entry_lo1;
    logic [5:0]                    r_tlb_slot;
    logic                          r_status;

    trpte_pkg::t_wr_req            wr_req;
    logic                          rd_en;
    logic [trpte_pkg::IDX_W-1:0]   rd_addr;
    trpte_pkg::t_entry             rd_rec;

    logic                          accept;
    logic                          issue;
    logic                          hit;
    logic                          partner;
    logic                          spare_full;
    logic                          out_free;
    logic [5:0]                    slot_rr;
    logic [19:0]                   frame_now;
    trpte_pkg::t_entry             new0;
    trpte_pkg::t_entry             new1;

    trpte_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_req),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_rec  (rd_rec)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign issue      = (r_state == S_SCAN) && !r_issue_done;
    assign partner    = (r_idx != trpte_pkg::LAST_IDX);
    assign spare_full = (({1'b0, r_next_spare} + 1'b1) >= trpte_pkg::PAGE_END);
    assign out_free   = !r_out_valid || i_out_ready;
    assign slot_rr    = ({1'b0, r_refill_slot} >= trpte_pkg::TLB_END) ? 6'd0 : r_refill_slot;
    assign frame_now  = trpte_pkg::FRAME_BASE + r_next_frame;

    always_comb begin
        hit = 1'b0;
        if (rd_rec.page_number[19:1] == r_target) begin
            if (r_action == trpte_pkg::ACT_REFILL) begin
                hit = !rd_rec.claimed || (rd_rec.owner == {1'b0, r_asid});
            end else begin
                hit = (rd_rec.owner == {1'b0, r_asid});
            end
        end
    end

    always_comb begin
        new0 = r_rec0;
        new1 = r_rec1;
        if (r_action == trpte_pkg::ACT_INVALID) begin
            new0.frame = frame_now;
            new0.valid = 1'b1;
            new1.frame = frame_now;
            new1.valid = 1'b1;
        end else begin
            new0.owner   = {1'b0, r_asid};
            new0.claimed = 1'b1;
            new1.owner   = {1'b0, r_asid};
            new1.claimed = 1'b1;
            if (r_spare) begin
                new0.page_number = {r_target, 1'b0};
                new1.page_number = {r_target, 1'b0};
            end
        end
    end

    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = r_scan_idx;
        wr_req.en   = 1'b0;
        wr_req.addr = r_idx;
        wr_req.rec  = new0;
        unique case (r_state)
            S_SCAN: begin
                rd_en = issue;
            end
            S_RD0: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
            end
            S_RD1: begin
                rd_en   = partner;
                rd_addr = r_idx + 1'b1;
            end
            S_WR0: begin
                wr_req.en = 1'b1;
            end
            S_WR1: begin
                wr_req.en   = partner;
                wr_req.addr = r_idx + 1'b1;
                wr_req.rec  = new1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_chk_vld && hit) begin
                    n_state = S_RD0;
                end else if (r_chk_vld && (r_chk_idx == trpte_pkg::LAST_IDX)) begin
                    if (r_action == trpte_pkg::ACT_INVALID) begin
                        n_state = S_IDLE;
                    end else if (spare_full) begin
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_RD0;
                    end
                end
            end
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_CAP1;
            S_CAP1: n_state = S_WR0;
            S_WR0:  n_state = S_WR1;
            S_WR1:  n_state = S_PUSH;
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_issue_done  <= 1'b0;
            r_chk_vld     <= 1'b0;
            r_next_frame  <= '0;
            r_next_spare  <= trpte_pkg::SPARE_RESET;
            r_refill_slot <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_PUSH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_issue_done <= 1'b0;
                    r_chk_vld    <= 1'b0;
                end
                S_SCAN: begin
                    r_chk_vld <= issue;
                    if (issue && (r_scan_idx == trpte_pkg::LAST_IDX)) begin
                        r_issue_done <= 1'b1;
                    end
                end
                S_WR0: begin
                    if (r_action == trpte_pkg::ACT_INVALID) begin
                        r_next_frame <= r_next_frame + 1'b1;
                    end
                end
                S_WR1: begin
                    if (r_action == trpte_pkg::ACT_INVALID) begin
                        r_next_frame <= r_next_frame + 1'b1;
                    end else begin
                        r_refill_slot <= slot_rr + 1'b1;
                        if (r_spare) begin
                            r_next_spare <= r_next_spare + 2'd2;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_action    <= i_action;
                r_target    <= i_bad_address[31:13];
                r_tlb_index <= i_tlb_index;
                r_asid      <= i_asid_in;
                r_scan_idx  <= '0;
                r_spare     <= 1'b0;
                r_exhaust   <= 1'b0;
            end
            S_SCAN: begin
                if (issue) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                r_chk_idx <= r_scan_idx;
                if (r_chk_vld && hit) begin
                    r_idx <= r_chk_idx;
                end else if (r_chk_vld && (r_chk_idx == trpte_pkg::LAST_IDX)) begin
                    r_idx     <= r_next_spare[trpte_pkg::IDX_W-1:0];
                    r_spare   <= 1'b1;
                    r_exhaust <= spare_full;
                end
            end
            S_RD1: begin
                r_rec0 <= rd_rec;
            end
            S_CAP1: begin
                r_rec1 <= rd_rec;
            end
            S_WR0: begin
                r_rec0 <= new0;
            end
            S_WR1: begin
                r_rec1 <= new1;
                r_slot <= (r_action == trpte_pkg::ACT_REFILL) ? slot_rr : r_tlb_index;
            end
            S_PUSH: begin
                if (out_free) begin
                    if (r_exhaust) begin
                        r_entry_hi  <= '0;
                        r_entry_lo0 <= '0;
                        r_entry_lo1 <= '0;
                        r_tlb_slot  <= '0;
                        r_status    <= trpte_pkg::STATUS_EXHAUSTED;
                    end else begin
                        r_entry_hi  <= {r_target, 5'd0, r_asid};
                        r_entry_lo0 <= trpte_pkg::pack_lo(r_rec0.frame, r_rec0.valid);
                        r_entry_lo1 <= partner ? trpte_pkg::pack_lo(r_rec1.frame, r_rec1.valid)
                                               : trpte_pkg::pack_lo(20'd0, 1'b0);
                        r_tlb_slot  <= r_slot;
                        r_status    <= trpte_pkg::STATUS_LOADED;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_entry_hi  = r_entry_hi;
    assign o_entry_lo0 = r_entry_lo0;
    assign o_entry_lo1 = r_entry_lo1;
    assign o_tlb_slot  = r_tlb_slot;
    assign o_status    = r_status;

    a_push_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) && r_out_valid && !i_out_ready |=> (r_state == S_PUSH))
        else $error("result pushed over an untaken item");

    a_exhaust_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == trpte_pkg::STATUS_EXHAUSTED)
            |-> (r_entry_hi == '0) && (r_tlb_slot == '0))
        else $error("exhaustion item carries a loaded entry");

    a_spare_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_next_spare} <= trpte_pkg::PAGE_END))
        else $error("spare pointer past table end");

    a_frame_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR1) && (r_action == trpte_pkg::ACT_INVALID)
            |=> (r_next_frame == $past(r_next_frame) + 20'd1))
        else $error("odd frame not consumed");

endmodule

`default_nettype wire

[bench/tlb_refill_page_table_engine_tb.sv]
// Self-checking testbench for the TLB refill page table engine: directed and random faults against a predictor.
`timescale 1ns / 1ps

module tlb_refill_page_table_engine_tb;

    localparam int   RANDOM_FAULTS    = 1590;
    localparam int   HIGH_PAIRS       = 24;
    localparam int   IDLE_PCT         = 13;
    localparam int   CALM_LO          = 700;
    localparam int   CALM_HI          = 1000;
    localparam int   HOLD_AT          = 300;
    localparam int   HOLD_CYCLES      = 1500;

    typedef struct packed {
        logic        action;
        logic [31:0] bad_address;
        logic [5:0]  tlb_index;
        logic [7:0]  asid;
    } t_fault;

    typedef struct packed {
        logic [31:0] entry_hi;
        logic [25:0] entry_lo0;
        logic [25:0] entry_lo1;
        logic [5:0]  tlb_slot;
        logic        status;
    } t_tlb_load;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_action = 1'b0;
    logic [31:0] i_bad_address = '0;
    logic [5:0]  i_tlb_index = '0;
    logic [7:0]  i_asid_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_entry_hi;
    logic [25:0] o_entry_lo0;
    logic [25:0] o_entry_lo1;
    logic [5:0]  o_tlb_slot;
    logic        o_status;

    tlb_refill_page_table_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_bad_address (i_bad_address),
        .i_tlb_index   (i_tlb_index),
        .i_asid_in     (i_asid_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_entry_hi    (o_entry_hi),
        .o_entry_lo0   (o_entry_lo0),
        .o_entry_lo1   (o_entry_lo1),
        .o_tlb_slot    (o_tlb_slot),
        .o_status      (o_status)
    );

    // page table shadow
    logic [19:0] pt_page    [trpte_pkg::PAGE_ENTRIES];
    logic [19:0] pt_frame   [trpte_pkg::PAGE_ENTRIES];
    logic        pt_valid   [trpte_pkg::PAGE_ENTRIES];
    logic        pt_claimed [trpte_pkg::PAGE_ENTRIES];
    logic [8:0]  pt_owner   [trpte_pkg::PAGE_ENTRIES];
    logic [19:0] frame_ctr;
    int          spare_ptr;
    int          rr_slot;

    t_fault      fault_q [$];
    t_tlb_load   load_q [$];
    t_fault      claims [$];
    logic [18:0] high_pairs [HIGH_PAIRS];
    logic [7:0]  asid_pool [4];

    int          total_faults = 0;
    int          faults_issued = 0;
    int          faults_accepted = 0;
    int          loads_checked = 0;
    int          mismatches = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic        fault_taken = 1'b0;
    t_fault      next_fault;
    t_fault      seen_fault;
    t_tlb_load   want;

    always #10 i_clk = ~i_clk;

    function automatic logic [25:0] lo_word(input int idx);
        if (idx >= trpte_pkg::PAGE_ENTRIES)
            return {20'h00000, trpte_pkg::LO_COHERENCY, trpte_pkg::LO_DIRTY, 1'b0, 1'b0};
        return {pt_frame[idx], trpte_pkg::LO_COHERENCY, trpte_pkg::LO_DIRTY,
                pt_valid[idx], 1'b0};
    endfunction

    function automatic t_tlb_load make_load(input int idx, input logic [7:0] asid,
                                            input logic [5:0] slot);
        t_tlb_load r;
        r.entry_hi  = {pt_page[idx] & 20'hFFFFE, 12'h000} | {24'h000000, asid};
        r.entry_lo0 = lo_word(idx);
        r.entry_lo1 = lo_word(idx + 1);
        r.tlb_slot  = slot;
        r.status    = trpte_pkg::STATUS_LOADED;
        return r;
    endfunction

    task automatic predict_fault(input t_fault f);
        logic [19:0] pair;
        int          i;
        int          idx;
        int          slot;
        bit          found;
        t_tlb_load   r;
        pair  = f.bad_address[31:12] & 20'hFFFFE;
        found = 1'b0;
        idx   = 0;
        if (f.action == trpte_pkg::ACT_INVALID) begin
            for (i = 0; i < trpte_pkg::PAGE_ENTRIES; i++) begin
                if (!found && (pt_page[i] & 20'hFFFFE) == pair &&
                    pt_owner[i] == {1'b0, f.asid}) begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (found) begin
                pt_frame[idx] = trpte_pkg::FRAME_BASE + frame_ctr;
                pt_valid[idx] = 1'b1;
                frame_ctr     = frame_ctr + 20'd1;
                if (idx + 1 < trpte_pkg::PAGE_ENTRIES) begin
                    pt_frame[idx + 1] = trpte_pkg::FRAME_BASE + frame_ctr;
                    pt_valid[idx + 1] = 1'b1;
                end
                frame_ctr = frame_ctr + 20'd1;
                load_q.push_back(make_load(idx, f.asid, f.tlb_index));
            end
        end else begin
            slot = (rr_slot >= trpte_pkg::TLB_ENTRIES) ? 0 : rr_slot;
            for (i = 0; i < trpte_pkg::PAGE_ENTRIES; i++) begin
                if (!found && (pt_page[i] & 20'hFFFFE) == pair &&
                    (!pt_claimed[i] || pt_owner[i] == {1'b0, f.asid})) begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (!found && spare_ptr + 1 >= trpte_pkg::PAGE_ENTRIES) begin
                r        = '0;
                r.status = trpte_pkg::STATUS_EXHAUSTED;
                load_q.push_back(r);
            end else begin
                if (!found) begin
                    idx              = spare_ptr;
                    pt_page[idx]     = pair;
                    pt_page[idx + 1] = pair;
                    spare_ptr        = spare_ptr + 2;
                end
                pt_owner[idx]   = {1'b0, f.asid};
                pt_claimed[idx] = 1'b1;
                if (idx + 1 < trpte_pkg::PAGE_ENTRIES) begin
                    pt_owner[idx + 1]   = {1'b0, f.asid};
                    pt_claimed[idx + 1] = 1'b1;
                end
                load_q.push_back(make_load(idx, f.asid, 6'(slot)));
                rr_slot = (slot + 1) & 63;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("load %0d: %s is %h, expected %h", loads_checked, what, got, exp_val);
        mismatches++;
    endtask

    task automatic add_fault(input logic action, input logic [31:0] addr,
                             input logic [5:0] index, input logic [7:0] asid);
        t_fault f;
        f.action      = action;
        f.bad_address = addr;
        f.tlb_index   = index;
        f.asid        = asid;
        fault_q.push_back(f);
    endtask

    function automatic logic [31:0] pick_address();
        logic [12:0] low;
        low = 13'($urandom);
        if ($urandom_range(0, 99) < 60)
            return {12'h000, 7'($urandom), low};
        return {high_pairs[$urandom_range(0, HIGH_PAIRS - 1)], low};
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || fault_taken)) begin
            if (fault_q.size() != 0 &&
                ((faults_issued >= CALM_LO && faults_issued < CALM_HI) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_fault    = fault_q.pop_front();
                i_in_valid    <= 1'b1;
                i_action      <= next_fault.action;
                i_bad_address <= next_fault.bad_address;
                i_tlb_index   <= next_fault.tlb_index;
                i_asid_in     <= next_fault.asid;
                faults_issued++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && loads_checked >= HOLD_AT) begin
                hold_done   = 1'b1;
                hold_left   = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (loads_checked >= CALM_LO && loads_checked < CALM_HI) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // accept and check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            fault_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                seen_fault.action      = i_action;
                seen_fault.bad_address = i_bad_address;
                seen_fault.tlb_index   = i_tlb_index;
                seen_fault.asid        = i_asid_in;
                predict_fault(seen_fault);
                faults_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (load_q.size() == 0) begin
                    report_mismatch("unexpected entry_hi", o_entry_hi, 32'h0);
                end else begin
                    want = load_q.pop_front();
                    if (o_entry_hi !== want.entry_hi)
                        report_mismatch("entry_hi", o_entry_hi, want.entry_hi);
                    if (o_entry_lo0 !== want.entry_lo0)
                        report_mismatch("entry_lo0", 32'(o_entry_lo0), 32'(want.entry_lo0));
                    if (o_entry_lo1 !== want.entry_lo1)
                        report_mismatch("entry_lo1", 32'(o_entry_lo1), 32'(want.entry_lo1));
                    if (o_tlb_slot !== want.tlb_slot)
                        report_mismatch("tlb_slot", 32'(o_tlb_slot), 32'(want.tlb_slot));
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                end
                loads_checked++;
            end
        end
    end

    initial begin
        int     n;
        int     kind;
        t_fault f;
        t_fault o;
        for (n = 0; n < trpte_pkg::PAGE_ENTRIES; n++) begin
            pt_page[n]    = 20'(n);
            pt_frame[n]   = '0;
            pt_valid[n]   = 1'b0;
            pt_claimed[n] = 1'b0;
            pt_owner[n]   = trpte_pkg::OWNER_UNOWNED;
        end
        frame_ctr = '0;
        spare_ptr = trpte_pkg::SPARE_START;
        rr_slot   = 0;
        for (n = 0; n < HIGH_PAIRS; n++)
            high_pairs[n] = 19'($urandom) | 19'h00080;
        for (n = 0; n < 4; n++)
            asid_pool[n] = 8'($urandom);

        add_fault(trpte_pkg::ACT_REFILL,  32'h0000_0000, 6'h00, 8'h00);
        add_fault(trpte_pkg::ACT_INVALID, 32'h0000_1FFF, 6'h3F, 8'h00);
        add_fault(trpte_pkg::ACT_INVALID, 32'h0000_0000, 6'h15, 8'hFF);
        add_fault(trpte_pkg::ACT_REFILL,  32'h0000_1000, 6'h3F, 8'hFF);
        add_fault(trpte_pkg::ACT_INVALID, 32'h0000_0000, 6'h2A, 8'hFF);
        add_fault(trpte_pkg::ACT_REFILL,  32'hFFFF_FFFF, 6'h15, 8'h80);
        add_fault(trpte_pkg::ACT_INVALID, 32'hFFFF_E000, 6'h3F, 8'h80);
        add_fault(trpte_pkg::ACT_REFILL,  32'h000F_E000, 6'h2A, 8'h01);
        add_fault(trpte_pkg::ACT_INVALID, 32'h000F_F123, 6'h01, 8'h01);
        add_fault(trpte_pkg::ACT_REFILL,  32'h000F_E000, 6'h00, 8'h01);
        add_fault(trpte_pkg::ACT_REFILL,  32'h8000_0000, 6'h3F, 8'h7F);
        add_fault(trpte_pkg::ACT_INVALID, 32'h8000_1555, 6'h20, 8'h7F);
        add_fault(trpte_pkg::ACT_REFILL,  32'h0000_2AAA, 6'h3F, 8'hAA);
        add_fault(trpte_pkg::ACT_INVALID, 32'h5555_5555, 6'h2A, 8'h55);
        add_fault(trpte_pkg::ACT_REFILL,  32'h7FFF_E000, 6'h00, 8'hFF);

        for (n = 0; n < RANDOM_FAULTS; n++) begin
            kind          = $urandom_range(0, 99);
            f.action      = trpte_pkg::ACT_REFILL;
            f.bad_address = pick_address();
            f.tlb_index   = 6'($urandom);
            f.asid        = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                        : asid_pool[$urandom_range(0, 3)];
            if (kind < 8) begin
                f.action      = 1'($urandom);
                f.bad_address = $urandom;
            end else if (kind < 45 && claims.size() != 0) begin
                o             = claims[$urandom_range(0, claims.size() - 1)];
                f.action      = trpte_pkg::ACT_INVALID;
                f.bad_address = {o.bad_address[31:13], 13'($urandom)};
                f.asid        = o.asid;
            end else if (kind < 52) begin
                f.action = trpte_pkg::ACT_INVALID;
            end else begin
                claims.push_back(f);
                if (claims.size() > 48)
                    claims.delete(0);
            end
            fault_q.push_back(f);
        end
        total_faults = fault_q.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (faults_accepted != total_faults)
            @(negedge i_clk);
        while (load_q.size() != 0)
            @(negedge i_clk);
        repeat (trpte_pkg::PAGE_ENTRIES + 20) @(negedge i_clk);

        if (mismatches == 0 && load_q.size() == 0)
            $display("tlb_refill_page_table_engine_tb OK");
        else
            $display("tlb_refill_page_table_engine_tb NOT OK");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tlb_refill_page_table_engine_tb NOT OK");
        $finish;
    end

endmodule
